// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, command and status codes,
// and the control bundle that the top level sends down the cell row.
// No dependencies.
`default_nettype none

package spq_pkg;

  // Queue geometry and stored widths
  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed widths of the channel fields
  localparam int CMD_W    = 2;
  localparam int PRIO_W   = 16;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic signed [PRIO_BITS-1:0] prio_t;
  typedef logic [DATA_BITS-1:0]        data_t;

  // Broadcast to every cell for one request
  typedef struct packed {
    logic  ins;
    logic  pop;
    prio_t new_prio;
    data_t new_data;
  } spq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for the sorted priority queue:
// one for requests, one for results. Depends on spq_pkg.
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [PRIO_W-1:0] priority_req;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output command, output priority_req, output element,
                  input ready);
  modport sink   (input valid, input command, input priority_req, input element,
                  output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ELEM_W-1:0]   head_element;
  logic                head_valid;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output head_element, output head_valid,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input head_element, input head_valid,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds a priority and payload, and on each
// request keeps, takes the new entry, or takes a neighbor. Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic     clk,
  input  wire spq_ctl_t ctl,
  input  wire logic     occ,        // slot lies below the entry count
  input  wire logic     ge_left,    // left neighbor stays in place on insert
  input  wire prio_t    left_prio,
  input  wire data_t    left_data,
  input  wire prio_t    right_prio,
  input  wire data_t    right_data,
  output logic          ge,
  output prio_t         prio_q,
  output data_t         data_q,
  output data_t         data_nxt
);

  prio_t prio_r, prio_nxt;
  data_t data_r;

  // Equal priorities stay ahead of the new entry
  assign ge = occ && (prio_r >= ctl.new_prio);

  always_comb begin
    prio_nxt = prio_r;
    data_nxt = data_r;
    if (ctl.ins && !ge) begin
      if (ge_left) begin
        prio_nxt = ctl.new_prio;
        data_nxt = ctl.new_data;
      end else begin
        prio_nxt = left_prio;
        data_nxt = left_data;
      end
    end else if (ctl.pop) begin
      prio_nxt = right_prio;
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    data_r <= data_nxt;
  end

  assign prio_q = prio_r;
  assign data_q = data_r;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue built from a row of DEPTH slot cells, head at cell 0.
// The result of a request is registered as the request is accepted.
// Throughput: one request per cycle while the result side is ready or no
// result is pending; every insert, pop, peek or clear is done as the cell row shifts or settles.
// Reset clears the entry count and the result valid; slot contents are
// left as they are and never read above the count.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [ELEM_W-1:0] head_r, head_nxt;

  logic       accept;
  spq_ctl_t   ctl;
  logic [DEPTH-1:0] occ, ge;
  prio_t      cell_prio [DEPTH];
  data_t      cell_data [DEPTH];
  data_t      cell_nxt  [DEPTH];
  cmd_t       cmd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.command);

  // Decode the request into shift controls, the new count and the status
  always_comb begin
    ctl.ins      = 1'b0;
    ctl.pop      = 1'b0;
    ctl.new_prio = prio_t'(in_ch.priority_req);
    ctl.new_data = data_t'(in_ch.element);
    count_nxt    = count_r;
    status_nxt   = ST_DONE;
    case (cmd)
      CMD_INSERT: begin
        if (count_r == CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.ins   = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.pop   = accept;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_PEEK:  count_nxt = count_r;
      CMD_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[i]),
        .ge_left    (1'b1),
        .left_prio  (ctl.new_prio),
        .left_data  (ctl.new_data),
        .right_prio (cell_prio[i+1]),
        .right_data (cell_data[i+1]),
        .ge         (ge[i]),
        .prio_q     (cell_prio[i]),
        .data_q     (cell_data[i]),
        .data_nxt   (cell_nxt[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      // Tail takes its own value on pop; the count drops past it anyway
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[i]),
        .ge_left    (ge[i-1]),
        .left_prio  (cell_prio[i-1]),
        .left_data  (cell_data[i-1]),
        .right_prio (cell_prio[i]),
        .right_data (cell_data[i]),
        .ge         (ge[i]),
        .prio_q     (cell_prio[i]),
        .data_q     (cell_data[i]),
        .data_nxt   (cell_nxt[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[i]),
        .ge_left    (ge[i-1]),
        .left_prio  (cell_prio[i-1]),
        .left_data  (cell_data[i-1]),
        .right_prio (cell_prio[i+1]),
        .right_data (cell_data[i+1]),
        .ge         (ge[i]),
        .prio_q     (cell_prio[i]),
        .data_q     (cell_data[i]),
        .data_nxt   (cell_nxt[i])
      );
    end
  end

  // Report the head as it stands after the request
  assign head_nxt = (count_nxt != '0) ? ELEM_W'(cell_nxt[0]) : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.head_element = head_r;
  assign out_ch.head_valid   = (count_r != '0);
  assign out_ch.entry_count  = COUNT_W'(count_r);

endmodule

`default_nettype wire

// ===== tb/spq_tb_pkg.sv =====
// Scoreboard for the sorted priority queue testbench: a shadow copy of the
// sorted slots that predicts each result and checks the ones that come back.
// Depends on spq_pkg.

package spq_tb_pkg;
  import spq_pkg::*;

  typedef struct {
    status_t            status;
    logic [ELEM_W-1:0]  head_element;
    logic               head_valid;
    logic [COUNT_W-1:0] entry_count;
  } queue_view_t;

  class queue_scoreboard;
    prio_t       slot_prio [DEPTH];
    data_t       slot_data [DEPTH];
    int unsigned held;
    int unsigned mismatches;
    queue_view_t expected_views [$];

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    // Apply one request to the shadow slots and return its status.
    function status_t apply_request(cmd_t cmd, prio_t prio, data_t data);
      int unsigned pos;
      int unsigned i;
      status_t     st;
      st = ST_DONE;
      case (cmd)
        CMD_INSERT: begin
          if (held >= DEPTH) begin
            st = ST_FULL;
          end else begin
            // go behind every entry of greater or equal priority
            pos = 0;
            while (pos < held && slot_prio[pos] >= prio) pos++;
            for (i = held; i > pos; i--) begin
              slot_prio[i] = slot_prio[i-1];
              slot_data[i] = slot_data[i-1];
            end
            slot_prio[pos] = prio;
            slot_data[pos] = data;
            held++;
          end
        end
        CMD_POP: begin
          if (held == 0) begin
            st = ST_EMPTY;
          end else begin
            for (i = 0; i + 1 < held; i++) begin
              slot_prio[i] = slot_prio[i+1];
              slot_data[i] = slot_data[i+1];
            end
            held--;
          end
        end
        CMD_PEEK: begin
        end
        CMD_CLEAR: begin
          held = 0;
        end
        default: begin
          st = ST_DONE;
        end
      endcase
      return st;
    endfunction

    function void accept_request(cmd_t cmd, logic [PRIO_W-1:0] prio_bits,
                                 logic [ELEM_W-1:0] elem);
      queue_view_t view;
      prio_t       prio;
      data_t       data;
      prio              = prio_bits;
      data              = elem;
      view.status       = apply_request(cmd, prio, data);
      view.head_valid   = (held != 0);
      view.head_element = (held != 0) ? slot_data[0] : '0;
      view.entry_count  = COUNT_W'(held);
      expected_views.push_back(view);
    endfunction

    function void report_field(real t_ns, string field, logic [31:0] want, logic [31:0] got);
      $display("%0.1f ns: %s mismatch, expected %h, actual %h", t_ns, field, want, got);
      mismatches++;
    endfunction

    function void check_result(real t_ns, logic [STATUS_W-1:0] status,
                               logic [ELEM_W-1:0] head_element, logic head_valid,
                               logic [COUNT_W-1:0] entry_count);
      queue_view_t want;
      if (expected_views.size() == 0) begin
        $display("%0.1f ns: result with no request pending, expected none, actual %0d/%h/%0b/%0d",
                 t_ns, status, head_element, head_valid, entry_count);
        mismatches++;
        return;
      end
      want = expected_views.pop_front();
      if (status !== want.status)
        report_field(t_ns, "status", want.status, status);
      if (head_element !== want.head_element)
        report_field(t_ns, "head_element", want.head_element, head_element);
      if (head_valid !== want.head_valid)
        report_field(t_ns, "head_valid", want.head_valid, head_valid);
      if (entry_count !== want.entry_count)
        report_field(t_ns, "entry_count", want.entry_count, entry_count);
    endfunction

    function int unsigned waiting();
      return expected_views.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_sorted_priority_queue.sv =====
// Top testbench for sorted_priority_queue: drives requests with random gaps,
// stalls the result side, and checks every result through queue_scoreboard.
// Depends on spq_pkg, spq_if and spq_tb_pkg.

module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 1800;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  bit   hold_request;
  int unsigned quiet_cycles = 0;

  queue_scoreboard board;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5ns clk = ~clk;

  // Observe both channels and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.accept_request(cmd_t'(in_ch.command), in_ch.priority_req, in_ch.element);
      if (out_ch.valid && out_ch.ready)
        board.check_result($realtime, out_ch.status, out_ch.head_element,
                           out_ch.head_valid, out_ch.entry_count);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Enter and leave at a falling edge; hold the request until taken.
  task automatic send_request(input cmd_t cmd, input logic [PRIO_W-1:0] prio,
                              input logic [ELEM_W-1:0] elem);
    while (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.priority_req <= prio;
    in_ch.element      <= elem;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    int          n;
    int          roll;
    int          insert_share;
    bit          filling;
    logic [15:0] prio;
    rst_n              = 1'b0;
    calm               = 1'b0;
    hold_request       = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_PEEK;
    in_ch.priority_req = '0;
    in_ch.element      = '0;
    board              = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty queue corners
    send_request(CMD_POP,   16'h0000, 32'h0);
    send_request(CMD_PEEK,  16'h0000, 32'h0);
    send_request(CMD_CLEAR, 16'h0000, 32'h0);
    // Priority extremes and ties in arrival order
    send_request(CMD_INSERT, 16'h7FFF, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 16'h8000, 32'h0000_0000);
    send_request(CMD_INSERT, 16'd5,    32'hA5A5_A5A5);
    send_request(CMD_INSERT, 16'd5,    32'h5A5A_5A5A);
    send_request(CMD_INSERT, 16'hFFFF, 32'h0000_0001);
    send_request(CMD_PEEK,   16'h0000, 32'h0);
    send_request(CMD_POP,    16'h0000, 32'h0);
    send_request(CMD_POP,    16'h0000, 32'h0);
    // Fill up and overflow by one
    for (n = 0; n < 14; n++)
      send_request(CMD_INSERT, 16'(n - 7), 32'(n) << 20);
    send_request(CMD_CLEAR, 16'h0000, 32'h0);
    send_request(CMD_POP,   16'h0000, 32'h0);

    filling = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) filling = !filling;
      if (n == 500) hold_request = 1'b1;
      calm = (n >= 900 && n < 1200);
      case ($urandom_range(9))
        0, 1, 2, 3: prio = 16'($signed($urandom_range(6)) - 3);
        4: begin
          case ($urandom_range(3))
            0: prio = 16'h7FFF;
            1: prio = 16'h8000;
            2: prio = 16'h0000;
            default: prio = 16'hFFFF;
          endcase
        end
        default: prio = 16'($urandom);
      endcase
      insert_share = filling ? 60 : 30;
      roll = $urandom_range(99);
      if (roll < 3)
        send_request(CMD_CLEAR, prio, $urandom);
      else if (roll < 15)
        send_request(CMD_PEEK, prio, $urandom);
      else if (roll < 15 + insert_share)
        send_request(CMD_INSERT, prio, $urandom);
      else
        send_request(CMD_POP, prio, $urandom);
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (board.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
